/* rtl/vlp_pkg.sv */
// Package for the number literal parser: phase, base and status codes,
// character constants and the digit decode functions.
// No dependencies.
package vlp_pkg;

    localparam int unsigned ACC_W       = 64;
    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned WIDTH_W     = 6;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned OUT_DATA_W  = 40;
    localparam logic [WIDTH_W-1:0] PLAIN_LIT_WIDTH = 6'd32;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_TICK       = 8'h27;
    localparam logic [7:0] CH_B          = 8'h62;
    localparam logic [7:0] CH_O          = 8'h6F;
    localparam logic [7:0] CH_D          = 8'h64;
    localparam logic [7:0] CH_H          = 8'h68;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'b001,
        PH_BASE   = 3'b010,
        PH_DIGITS = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        BASE_UNKNOWN = 3'd0,
        BASE_BIN     = 3'd1,
        BASE_OCT     = 3'd2,
        BASE_DEC     = 3'd3,
        BASE_HEX     = 3'd4
    } t_base;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_WIDE      = 2'd1,
        ST_BAD_BASE  = 2'd2
    } t_status;

    localparam logic [4:0] NO_DIGIT = 5'd16;

    // Value of a hex digit in either case, or NO_DIGIT for anything else.
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = NO_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h37);
        end
        return d;
    endfunction

    function automatic logic [4:0] radix_of(input t_base b);
        logic [4:0] r;
        case (b)
            BASE_BIN: r = 5'd2;
            BASE_OCT: r = 5'd8;
            BASE_HEX: r = 5'd16;
            default:  r = 5'd10;
        endcase
        return r;
    endfunction

    function automatic t_base base_of(input logic [7:0] c);
        t_base b;
        case (c)
            CH_B:    b = BASE_BIN;
            CH_O:    b = BASE_OCT;
            CH_D:    b = BASE_DEC;
            CH_H:    b = BASE_HEX;
            default: b = BASE_UNKNOWN;
        endcase
        return b;
    endfunction

endpackage

/* rtl/verilog_literal_parser.sv */
// Top level of the number literal parser: input register, parse state and result register.
// Depends on vlp_pkg and vlp_sat_mac.
//
//   channel  dir  tdata (low bit first)         tuser / tlast
//   s_axis   in   ch[7:0]                       tlast = last character
//   m_axis   out  value[31:0] width[5:0] status[1:0]  none
//
// One character per cycle unless a stalled result holds back a final character. Each
// goes through the input register into the parse state or, if final, the result register.
// Reset returns the parse state to the lead digits phase and empties both registers.
// A stalled result holds back only a final character; other characters keep flowing.
module verilog_literal_parser #(
    parameter int unsigned MAX_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // ch[7:0]
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [vlp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata  // value[31:0], width[37:32],
                                                           // status[39:38]
);
    import vlp_pkg::*;

    logic              r_in_valid;
    logic [7:0]        r_in_ch;
    logic              r_in_last;

    t_phase            r_phase,     n_phase;
    logic [ACC_W-1:0]  r_lead_acc,  n_lead_acc;
    logic              r_lead_stop, n_lead_stop;
    logic              r_lead_seen, n_lead_seen;
    t_base             r_base,      n_base;
    logic [ACC_W-1:0]  r_dig_acc,   n_dig_acc;
    logic              r_dig_stop,  n_dig_stop;

    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value, n_out_value;
    logic [WIDTH_W-1:0]  r_out_width, n_out_width;
    t_status             r_out_status, n_out_status;

    logic              out_free;
    logic              proc;
    logic [4:0]        digit;
    logic [ACC_W-1:0]  lead_mac;
    logic [ACC_W-1:0]  dig_mac;
    logic [ACC_W-1:0]  w_full;
    logic [6:0]        w_small;
    logic [VALUE_W-1:0] mask;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign proc            = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || proc;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_status, r_out_width, r_out_value};

    assign digit = digit_of(r_in_ch);

    vlp_sat_mac u_lead_mac (
        .i_acc   (r_lead_acc),
        .i_base  (BASE_DEC),
        .i_digit (digit[3:0]),
        .o_acc   (lead_mac)
    );

    vlp_sat_mac u_dig_mac (
        .i_acc   (r_dig_acc),
        .i_base  (r_base),
        .i_digit (digit[3:0]),
        .o_acc   (dig_mac)
    );

    always_comb begin
        n_phase     = r_phase;
        n_lead_acc  = r_lead_acc;
        n_lead_stop = r_lead_stop;
        n_lead_seen = r_lead_seen;
        n_base      = r_base;
        n_dig_acc   = r_dig_acc;
        n_dig_stop  = r_dig_stop;
        if (r_in_ch != CH_UNDERSCORE) begin
            case (r_phase)
                PH_LEAD: begin
                    if (r_in_ch == CH_TICK) begin
                        n_phase = PH_BASE;
                    end else begin
                        n_lead_seen = 1'b1;
                        if (!r_lead_stop) begin
                            if (digit < 5'd10) begin
                                n_lead_acc = lead_mac;
                            end else begin
                                n_lead_stop = 1'b1;
                            end
                        end
                    end
                end
                PH_BASE: begin
                    n_base  = base_of(r_in_ch);
                    n_phase = PH_DIGITS;
                end
                default: begin
                    if (!r_dig_stop) begin
                        if (digit < radix_of(r_base)) begin
                            n_dig_acc = dig_mac;
                        end else begin
                            n_dig_stop = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        w_full  = n_lead_seen ? n_lead_acc : ACC_W'(PLAIN_LIT_WIDTH);
        w_small = w_full[6:0];
        mask    = (w_small >= 7'd32) ? {VALUE_W{1'b1}}
                                     : ((VALUE_W'(1) << w_small[4:0]) - VALUE_W'(1));
        if (n_phase == PH_LEAD) begin
            n_out_value  = n_lead_acc[VALUE_W-1:0];
            n_out_width  = PLAIN_LIT_WIDTH;
            n_out_status = ST_OK;
        end else if (w_full > ACC_W'(MAX_WIDTH)) begin
            n_out_value  = '0;
            n_out_width  = '0;
            n_out_status = ST_WIDE;
        end else if (n_phase == PH_BASE || n_base == BASE_UNKNOWN) begin
            n_out_value  = '0;
            n_out_width  = w_full[WIDTH_W-1:0];
            n_out_status = ST_BAD_BASE;
        end else begin
            n_out_value  = n_dig_acc[VALUE_W-1:0] & mask;
            n_out_width  = w_full[WIDTH_W-1:0];
            n_out_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_LEAD;
            r_lead_acc  <= '0;
            r_lead_stop <= 1'b0;
            r_lead_seen <= 1'b0;
            r_base      <= BASE_DEC;
            r_dig_acc   <= '0;
            r_dig_stop  <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (proc && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (proc) begin
                if (r_in_last) begin
                    r_phase     <= PH_LEAD;
                    r_lead_acc  <= '0;
                    r_lead_stop <= 1'b0;
                    r_lead_seen <= 1'b0;
                    r_base      <= BASE_DEC;
                    r_dig_acc   <= '0;
                    r_dig_stop  <= 1'b0;
                end else begin
                    r_phase     <= n_phase;
                    r_lead_acc  <= n_lead_acc;
                    r_lead_stop <= n_lead_stop;
                    r_lead_seen <= n_lead_seen;
                    r_base      <= n_base;
                    r_dig_acc   <= n_dig_acc;
                    r_dig_stop  <= n_dig_stop;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_ch   <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (proc && r_in_last) begin
            r_out_value  <= n_out_value;
            r_out_width  <= n_out_width;
            r_out_status <= n_out_status;
        end
    end

endmodule

/* rtl/vlp_sat_mac.sv */
// Saturating multiply-accumulate by the radix of a base, built from shifts and adds.
// Depends on vlp_pkg.
module vlp_sat_mac (
    input  logic [vlp_pkg::ACC_W-1:0] i_acc,
    input  vlp_pkg::t_base            i_base,
    input  logic [3:0]                i_digit,
    output logic [vlp_pkg::ACC_W-1:0] o_acc
);
    import vlp_pkg::*;

    logic [ACC_W+3:0] prod;
    logic [ACC_W+3:0] sum;

    always_comb begin
        case (i_base)
            BASE_BIN: prod = {3'b000, i_acc, 1'b0};
            BASE_OCT: prod = {1'b0, i_acc, 3'b000};
            BASE_HEX: prod = {i_acc, 4'b0000};
            default:  prod = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0};
        endcase
        sum   = prod + {{ACC_W{1'b0}}, i_digit};
        o_acc = (|sum[ACC_W+3:ACC_W]) ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    end

endmodule

/* dv/verilog_literal_parser_checker.sv */
// Checker for the number literal parser: watches both stream channels, predicts each result
// from the accepted characters and compares it field by field with the one that arrives.
// Depends on vlp_pkg.
module verilog_literal_parser_checker #(
    parameter int unsigned MAX_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // ch[7:0]
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,    // value[31:0], width[37:32], status[39:38]
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import vlp_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [5:0]  width;
        logic [31:0] value;
    } t_lit_result;

    t_lit_result expected_literals[$];

    t_phase      cur_phase;
    logic [63:0] lead_acc;
    logic        lead_halt;
    logic        lead_any;
    t_base       base_sel;
    logic [63:0] digit_acc;
    logic        digit_halt;

    function automatic logic [4:0] char_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return 5'(c - "0");
        end
        if (c >= "a" && c <= "f") begin
            return 5'(c - "a" + 8'd10);
        end
        if (c >= "A" && c <= "F") begin
            return 5'(c - "A" + 8'd10);
        end
        return 5'd16;
    endfunction

    function automatic logic [63:0] mac_sat(input logic [63:0] acc, input logic [4:0] radix,
                                            input logic [4:0] d);
        logic [71:0] sum;
        sum = 72'(acc) * 72'(radix) + 72'(d);
        return (sum[71:64] != 8'd0) ? {64{1'b1}} : sum[63:0];
    endfunction

    task automatic clear_parse();
        cur_phase  = PH_LEAD;
        lead_acc   = '0;
        lead_halt  = 1'b0;
        lead_any   = 1'b0;
        base_sel   = BASE_DEC;
        digit_acc  = '0;
        digit_halt = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last);
        logic [4:0]  radix;
        logic [4:0]  d;
        logic [63:0] w;
        t_lit_result r;
        if (c != CH_UNDERSCORE) begin
            case (cur_phase)
                PH_LEAD: begin
                    if (c == CH_TICK) begin
                        cur_phase = PH_BASE;
                    end else begin
                        lead_any = 1'b1;
                        if (!lead_halt) begin
                            d = char_digit(c);
                            if (d < 5'd10) begin
                                lead_acc = mac_sat(lead_acc, 5'd10, d);
                            end else begin
                                lead_halt = 1'b1;
                            end
                        end
                    end
                end
                PH_BASE: begin
                    case (c)
                        CH_B:    base_sel = BASE_BIN;
                        CH_O:    base_sel = BASE_OCT;
                        CH_D:    base_sel = BASE_DEC;
                        CH_H:    base_sel = BASE_HEX;
                        default: base_sel = BASE_UNKNOWN;
                    endcase
                    cur_phase = PH_DIGITS;
                end
                default: begin
                    if (!digit_halt) begin
                        case (base_sel)
                            BASE_BIN: radix = 5'd2;
                            BASE_OCT: radix = 5'd8;
                            BASE_HEX: radix = 5'd16;
                            default:  radix = 5'd10;
                        endcase
                        d = char_digit(c);
                        if (d < radix) begin
                            digit_acc = mac_sat(digit_acc, radix, d);
                        end else begin
                            digit_halt = 1'b1;
                        end
                    end
                end
            endcase
        end
        if (last) begin
            if (cur_phase == PH_LEAD) begin
                r.value  = lead_acc[31:0];
                r.width  = PLAIN_LIT_WIDTH;
                r.status = ST_OK;
            end else begin
                w = lead_any ? lead_acc : 64'(PLAIN_LIT_WIDTH);
                if (w > 64'(MAX_WIDTH)) begin
                    r.status = ST_WIDE;
                    r.value  = '0;
                    w        = '0;
                end else if (cur_phase == PH_BASE || base_sel == BASE_UNKNOWN) begin
                    r.status = ST_BAD_BASE;
                    r.value  = '0;
                end else begin
                    r.status = ST_OK;
                    r.value  = (w >= 64'd32) ? digit_acc[31:0]
                                             : digit_acc[31:0] & 32'((64'd1 << w) - 64'd1);
                end
                r.width = w[5:0];
            end
            expected_literals.push_back(r);
            clear_parse();
        end
    endtask

    always @(posedge i_clk) begin
        t_lit_result got;
        t_lit_result want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            expected_literals.delete();
            clear_parse();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_lit_result'(i_m_tdata);
                if (expected_literals.size() == 0) begin
                    report_mismatch($sformatf("unexpected result transfer %010h", i_m_tdata));
                end else begin
                    want = expected_literals.pop_front();
                    if (got.value !== want.value) begin
                        report_mismatch($sformatf("value %08h, expected %08h",
                                                  got.value, want.value));
                    end
                    if (got.width !== want.width) begin
                        report_mismatch($sformatf("width %0d, expected %0d",
                                                  got.width, want.width));
                    end
                    if (got.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                parse_char(i_s_tdata, i_s_tlast);
            end
        end
        o_pending = expected_literals.size();
    end

endmodule

/* dv/verilog_literal_parser_test.sv */
// Top of the number literal parser testbench: clock, reset, character stimulus and result sink.
// Depends on vlp_pkg, verilog_literal_parser and verilog_literal_parser_checker.
module verilog_literal_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vlp_pkg::*;

    localparam int unsigned LIT_MAX_WIDTH = 32;
    localparam int unsigned CHAR_TARGET   = 1450;
    localparam int unsigned GAP_MAX       = 18;
    localparam int unsigned DRAIN_CYCLES  = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // ch[7:0]
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;   // value[31:0], width[37:32], status[39:38]

    int          fail_count;
    int          pending;
    logic [7:0]  text_q[$];
    bit          sender_burst;
    bit          receiver_burst;
    int unsigned chars_sent;

    always #5 i_clk = ~i_clk;

    verilog_literal_parser #(
        .MAX_WIDTH(LIT_MAX_WIDTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    verilog_literal_parser_checker #(
        .MAX_WIDTH(LIT_MAX_WIDTH)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tlast    (i_s_axis_tlast),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic [7:0] digit_char(input int unsigned radix);
        int unsigned d;
        d = $urandom_range(0, radix - 1);
        if (d < 10) begin
            return 8'("0" + d);
        end
        if ($urandom_range(0, 1) == 0) begin
            return 8'("a" + d - 10);
        end
        return 8'("A" + d - 10);
    endfunction

    task automatic push_text(input string s, input bit sprinkle);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
            if (sprinkle && $urandom_range(0, 7) == 0) begin
                text_q.push_back(CH_UNDERSCORE);
            end
        end
    endtask

    task automatic send_queue();
        int unsigned gap;
        for (int i = 0; i < text_q.size(); i++) begin
            gap = sender_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_s_axis_tdata  = text_q[i];
            i_s_axis_tlast  = (i + 1 == text_q.size());
            i_s_axis_tvalid = 1'b1;
            do @(posedge i_clk); while (!o_s_axis_tready);
            @(negedge i_clk);
            if (text_q[i] != CH_UNDERSCORE) begin
                chars_sent++;
            end
        end
        text_q.delete();
    endtask

    task automatic send_text(input string s);
        push_text(s, 1'b0);
        send_queue();
    endtask

    task automatic build_literal();
        int unsigned kind;
        int unsigned sel;
        int unsigned w;
        int unsigned n;
        int unsigned radix;
        logic [7:0]  base_ch;
        bit          cut;
        kind = $urandom_range(0, 99);
        cut  = 1'b0;
        if (kind < 12) begin
            n = $urandom_range(1, 8);
            repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 27) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(19, 26) : $urandom_range(1, 9);
            repeat (n) begin
                text_q.push_back(digit_char(10));
                if ($urandom_range(0, 7) == 0) begin
                    text_q.push_back(CH_UNDERSCORE);
                end
            end
        end else begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: begin
                    if ($urandom_range(0, 1) == 0) begin
                        text_q.push_back(CH_UNDERSCORE);
                    end
                end
                1: push_text($sformatf("%0d", $urandom_range(33, 999)), 1'b1);
                2: push_text(($urandom_range(0, 1) == 0) ? "0" : "32", 1'b1);
                3: begin
                    if ($urandom_range(0, 1) == 0) begin
                        text_q.push_back(digit_char(10));
                    end
                    text_q.push_back(8'($urandom_range("g", "z")));
                    if ($urandom_range(0, 1) == 0) begin
                        text_q.push_back(digit_char(10));
                    end
                end
                default: begin
                    w = $urandom_range(1, 32);
                    push_text($sformatf("%0d", w), 1'b1);
                end
            endcase
            text_q.push_back(CH_TICK);
            if (kind < 85) begin
                case ($urandom_range(0, 3))
                    0:       base_ch = CH_B;
                    1:       base_ch = CH_O;
                    2:       base_ch = CH_D;
                    default: base_ch = CH_H;
                endcase
                text_q.push_back(base_ch);
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        base_ch = 8'($urandom_range(0, 255));
                        text_q.push_back(base_ch);
                    end
                    1: cut = 1'b1;
                    default: begin
                        base_ch = CH_TICK;
                        text_q.push_back(base_ch);
                    end
                endcase
            end
            if (!cut) begin
                case (base_ch)
                    CH_B:    radix = 2;
                    CH_O:    radix = 8;
                    CH_H:    radix = 16;
                    default: radix = 10;
                endcase
                case ($urandom_range(0, 9))
                    0:       n = 0;
                    1:       n = $urandom_range(17, 70);
                    default: n = $urandom_range(1, 10);
                endcase
                repeat (n) begin
                    text_q.push_back(digit_char(radix));
                    if ($urandom_range(0, 7) == 0) begin
                        text_q.push_back(CH_UNDERSCORE);
                    end
                end
                if ($urandom_range(0, 5) == 0) begin
                    n = $urandom_range(1, 5);
                    repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        int unsigned gap;
        int unsigned taken;
        i_m_axis_tready = 1'b0;
        receiver_burst  = 1'b0;
        taken           = 0;
        @(posedge i_rst_n);
        forever begin
            if (taken % 16 == 0) begin
                receiver_burst = ($urandom_range(0, 3) == 0);
            end
            gap = receiver_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            @(negedge i_clk);
            taken++;
        end
    end

    initial begin
        #4_000_000;
        $display("FAIL verilog_literal_parser");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        sender_burst    = 1'b0;
        chars_sent      = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_text("7");
        send_text("'b");
        send_text("8'hfF");
        send_text("40'd1");
        send_text("3'x");
        send_text("2'");
        send_text("a'o7");
        send_text("4''");
        sender_burst = 1'b1;
        push_text("1_0", 1'b0);
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        send_queue();

        while (chars_sent < CHAR_TARGET) begin
            sender_burst = ($urandom_range(0, 4) == 0);
            build_literal();
            send_queue();
        end
        i_s_axis_tvalid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS verilog_literal_parser");
        end else begin
            $display("FAIL verilog_literal_parser");
        end
        $finish;
    end

endmodule

/* verilog_literal_parser.f */
rtl/vlp_pkg.sv
rtl/vlp_sat_mac.sv
rtl/verilog_literal_parser.sv
dv/verilog_literal_parser_checker.sv
dv/verilog_literal_parser_test.sv
